// ----- design/dba_pkg.sv -----
// ---------------------------------------------------------------------------
// dba_pkg: shared types and constants of the disk block allocator
// Command and status codes, beat structs, sequencer states, defaults.
// ---------------------------------------------------------------------------
package dba_pkg;

    localparam int NUM_BLOCKS_DEF      = 256;
    localparam int MAX_FILES_DEF       = 64;
    localparam int MAX_FILE_BLOCKS_DEF = 64;

    localparam int CMD_W  = 3;
    localparam int KEY_W  = 16;
    localparam int SIZE_W = 24;
    localparam int BU_W   = 9;
    localparam int BPB_W  = 16;
    localparam int STAT_W = 3;
    localparam int BNUM_W = 8;
    localparam int ORD_W  = 6;

    localparam logic [CMD_W-1:0] CMD_CREATE_CONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE_SCAT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COMPACT     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_RUN     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd4;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE  = 3'd5;

    localparam logic CFG_BLOCKS_IN_USE   = 1'b0;
    localparam logic CFG_BYTES_PER_BLOCK = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  file_key;
        logic [SIZE_W-1:0] size_bytes;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              has_block;
        logic [BNUM_W-1:0] block_number;
        logic [ORD_W-1:0]  block_ordinal;
        logic              last;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_COUNT,
        S_CMP,
        S_RP_START,
        S_RP_ORD,
        S_RP_SLOT,
        S_RP_CNT,
        S_RP_FILL,
        S_SLOT,
        S_RUN,
        S_EMIT_C,
        S_SCAT,
        S_RECORD,
        S_DL_ORD,
        S_DL_SLOT,
        S_DL_KEY,
        S_DL_FREE,
        S_SH_RD,
        S_SH_WR,
        S_DL_END,
        S_SINGLE
    } t_state;

endpackage

// ----- design/dba_div.sv -----
// ---------------------------------------------------------------------------
// dba_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses once.
// ---------------------------------------------------------------------------
module dba_div import dba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SIZE_W-1:0] i_dividend,
    input  logic [BPB_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [SIZE_W-1:0] o_quotient,
    output logic [BPB_W-1:0]  o_remainder
);

    localparam int CNT_W = $clog2(SIZE_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [SIZE_W-1:0] r_quo;
    logic [BPB_W:0]    r_rem;
    logic [BPB_W-1:0]  r_div;
    logic [BPB_W:0]    shifted;
    logic [SIZE_W-1:0] n_quo;
    logic [BPB_W:0]    n_rem;

    always_comb begin
        shifted = {r_rem[BPB_W-1:0], r_quo[SIZE_W-1]};
        if (shifted >= {1'b0, r_div}) begin
            n_rem = shifted - {1'b0, r_div};
            n_quo = {r_quo[SIZE_W-2:0], 1'b1};
        end else begin
            n_rem = shifted;
            n_quo = {r_quo[SIZE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SIZE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem[BPB_W-1:0];

endmodule

// ----- design/dba_ram.sv -----
// ---------------------------------------------------------------------------
// dba_ram: simple dual-port memory
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module dba_ram import dba_pkg::*; #(
    parameter int DEPTH = MAX_FILES_DEF,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ----- design/disk_block_allocator_top.sv -----
// ---------------------------------------------------------------------------
// disk_block_allocator_top: bitmap block allocator with file table
// Usage: send one command beat on the in channel (valid/ready). Creates
// produce one out beat per allocated block (block number, ordinal, last on
// the final one); delete, compact, clear, failures and empty creates give a
// single beat with last set. Config writes (index 0 blocks_in_use, index 1
// bytes_per_block) are taken every cycle and must only come while idle.
// Flow: one command at a time; in_ready is high only in idle. A create
// runs the size division, a free-count scan over the managed blocks
// (blocks_in_use, clamped to NUM_BLOCKS), a scan for the lowest free slot,
// then a block scan that emits each allocated block; if free blocks fall
// short, a compaction first repacks every file's blocks from block 0 in
// table order and the free count is taken again. A delete searches the
// table in creation order for the key, sweeps the owner map (one
// owner-memory read a cycle) to free the file's blocks, then shifts the
// later table entries down. Reset: occupancy bitmap, slot-busy bits and
// file count clear at once; no memory sweep. Out stall: the output
// register holds its beat and the sequencer waits, losing nothing; the next
// command may be accepted while the final beat of the previous one still waits.
// ---------------------------------------------------------------------------
module disk_block_allocator_top import dba_pkg::*; #(
    parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
    parameter int MAX_FILES       = MAX_FILES_DEF,
    parameter int MAX_FILE_BLOCKS = MAX_FILE_BLOCKS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [BPB_W-1:0] i_cfg_data
);

    localparam int BW = $clog2(NUM_BLOCKS);       // block index
    localparam int AW = BW + 1;                    // block counter
    localparam int SW = $clog2(MAX_FILES);        // slot index
    localparam int CW = $clog2(MAX_FILES + 1);    // file count
    localparam int NW = $clog2(MAX_FILE_BLOCKS + 1);

    // state
    t_state              r_state, n_state;
    logic [NUM_BLOCKS-1:0] r_used, n_used;
    logic [MAX_FILES-1:0]  r_busy, n_busy;
    logic [CW-1:0]       r_file_count, n_file_count;
    logic [BU_W-1:0]     r_bu;
    logic [BPB_W-1:0]    r_bpb;
    logic [AW-1:0]       r_i, n_i;
    logic [AW-1:0]       r_free, n_free;
    logic [CW-1:0]       r_fi, n_fi;
    logic [NW-1:0]       r_n, n_n;
    logic [NW-1:0]       r_run, n_run;
    logic [NW-1:0]       r_left, n_left;
    logic [NW-1:0]       r_need, n_need;
    logic [SW-1:0]       r_slot, n_slot;
    logic [BW-1:0]       r_pa, n_pa;
    logic                r_pv, n_pv;
    logic [STAT_W-1:0]   r_status, n_status;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic                r_repacked, n_repacked;
    logic                r_out_valid;
    t_out_item           r_out;

    // datapath helpers
    logic                emit_en, can_emit;
    t_out_item           beat;
    logic [AW-1:0]       lim;
    logic [BW-1:0]       bidx;
    logic [NW-1:0]       n_inc, run_inc;
    logic [SIZE_W:0]     need_full;

    // divider
    logic                div_start, div_done;
    logic [SIZE_W-1:0]   div_quo;
    logic [BPB_W-1:0]    div_rem, divisor;

    // memories
    logic                own_we, key_we, cnt_we, ord_we;
    logic [BW-1:0]       own_waddr, own_raddr;
    logic [SW-1:0]       own_wdata, own_q;
    logic [SW-1:0]       key_waddr, key_raddr, cnt_waddr, cnt_raddr;
    logic [SW-1:0]       ord_waddr, ord_raddr, ord_wdata, ord_q;
    logic [KEY_W-1:0]    key_q;
    logic [NW-1:0]       cnt_q;

    assign divisor = (r_bpb == '0) ? BPB_W'(1) : r_bpb;

    dba_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_size),
        .i_divisor   (divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // owner map: slot owning each used block
    dba_ram #(.DEPTH(NUM_BLOCKS), .WIDTH(SW)) u_owner (
        .i_clk(i_clk), .i_we(own_we), .i_waddr(own_waddr), .i_wdata(own_wdata),
        .i_raddr(own_raddr), .o_rdata(own_q)
    );
    dba_ram #(.DEPTH(MAX_FILES), .WIDTH(KEY_W)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_waddr), .i_wdata(r_key),
        .i_raddr(key_raddr), .o_rdata(key_q)
    );
    dba_ram #(.DEPTH(MAX_FILES), .WIDTH(NW)) u_cnt (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_waddr), .i_wdata(r_need),
        .i_raddr(cnt_raddr), .o_rdata(cnt_q)
    );
    // file table in creation order
    dba_ram #(.DEPTH(MAX_FILES), .WIDTH(SW)) u_order (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_raddr(ord_raddr), .o_rdata(ord_q)
    );

    // managed block count, clamped to the built capacity
    always_comb begin
        if (32'(r_bu) > 32'(NUM_BLOCKS)) begin
            lim = AW'(NUM_BLOCKS);
        end else begin
            lim = AW'(r_bu);
        end
    end

    assign bidx      = r_i[BW-1:0];
    assign n_inc     = r_n + NW'(1);
    assign run_inc   = r_run + NW'(1);
    assign need_full = (SIZE_W+1)'(div_quo) + (SIZE_W+1)'(div_rem != '0);
    assign can_emit  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_busy       = r_busy;
        n_file_count = r_file_count;
        n_i          = r_i;
        n_free       = r_free;
        n_fi         = r_fi;
        n_n          = r_n;
        n_run        = r_run;
        n_left       = r_left;
        n_need       = r_need;
        n_slot       = r_slot;
        n_pa         = r_pa;
        n_pv         = r_pv;
        n_status     = r_status;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_size       = r_size;
        n_repacked   = r_repacked;
        div_start    = 1'b0;
        emit_en      = 1'b0;
        beat         = '0;
        own_we = 1'b0; own_waddr = bidx; own_wdata = r_slot; own_raddr = '0;
        key_we = 1'b0; key_waddr = r_slot; key_raddr = '0;
        cnt_we = 1'b0; cnt_waddr = r_slot; cnt_raddr = '0;
        ord_we = 1'b0; ord_waddr = '0; ord_wdata = r_slot; ord_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd      = i_in_data.cmd;
                    n_key      = i_in_data.file_key;
                    n_size     = i_in_data.size_bytes;
                    n_repacked = 1'b0;
                    n_status   = ST_OK;
                    n_fi       = '0;
                    unique case (i_in_data.cmd)
                        CMD_CREATE_CONT, CMD_CREATE_SCAT: n_state = S_DIV;
                        CMD_DELETE:  n_state = S_DL_ORD;
                        CMD_COMPACT: n_state = S_RP_START;
                        CMD_CLEAR: begin
                            n_used       = '0;
                            n_busy       = '0;
                            n_file_count = '0;
                            n_state      = S_SINGLE;
                        end
                        default: n_state = S_SINGLE;
                    endcase
                end
            end
            S_DIV: begin
                // start fires on the first cycle here, r_size now holds the size
                div_start = !r_repacked;
                n_repacked = 1'b1;
                if (div_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_repacked = 1'b0;
                n_need     = NW'(need_full);
                n_i        = '0;
                n_free     = '0;
                if (need_full > (SIZE_W+1)'(MAX_FILE_BLOCKS)) begin
                    n_status = ST_TOO_LARGE;
                    n_state  = S_SINGLE;
                end else if (32'(r_file_count) >= 32'(MAX_FILES)) begin
                    n_status = ST_TABLE_FULL;
                    n_state  = S_SINGLE;
                end else if (r_cmd == CMD_CREATE_CONT && need_full == '0) begin
                    n_status = ST_NO_RUN;
                    n_state  = S_SINGLE;
                end else begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                if (r_i == lim) begin
                    n_state = S_CMP;
                end else begin
                    if (!r_used[bidx]) begin
                        n_free = r_free + AW'(1);
                    end
                    n_i = r_i + AW'(1);
                end
            end
            S_CMP: begin
                n_slot = '0;
                if (32'(r_free) < 32'(r_need)) begin
                    if (r_repacked) begin
                        n_status = ST_NO_SPACE;
                        n_state  = S_SINGLE;
                    end else begin
                        n_state = S_RP_START;
                    end
                end else begin
                    n_state = S_SLOT;
                end
            end
            S_RP_START: begin
                n_used  = '0;
                n_i     = '0;
                n_fi    = '0;
                n_state = S_RP_ORD;
            end
            S_RP_ORD: begin
                ord_raddr = r_fi[SW-1:0];
                if (r_fi == r_file_count) begin
                    if (r_cmd == CMD_COMPACT) begin
                        n_state = S_SINGLE;
                    end else begin
                        // recount after compaction
                        n_repacked = 1'b1;
                        n_i        = '0;
                        n_free     = '0;
                        n_state    = S_COUNT;
                    end
                end else begin
                    n_state = S_RP_SLOT;
                end
            end
            S_RP_SLOT: begin
                n_slot    = ord_q;
                cnt_raddr = ord_q;
                n_state   = S_RP_CNT;
            end
            S_RP_CNT: begin
                n_left  = cnt_q;
                n_state = S_RP_FILL;
            end
            S_RP_FILL: begin
                if (r_left == '0 || r_i == AW'(NUM_BLOCKS)) begin
                    n_fi    = r_fi + CW'(1);
                    n_state = S_RP_ORD;
                end else begin
                    n_used[bidx] = 1'b1;
                    own_we       = 1'b1;
                    n_i          = r_i + AW'(1);
                    n_left       = r_left - NW'(1);
                end
            end
            S_SLOT: begin
                // lowest free slot; one exists since the table is not full
                if (!r_busy[r_slot]) begin
                    n_i   = '0;
                    n_n   = '0;
                    n_run = '0;
                    n_state = (r_cmd == CMD_CREATE_CONT) ? S_RUN : S_SCAT;
                end else begin
                    n_slot = r_slot + SW'(1);
                end
            end
            S_RUN: begin
                if (r_i == lim) begin
                    n_status = ST_NO_RUN;
                    n_state  = S_SINGLE;
                end else if (!r_used[bidx]) begin
                    if (run_inc == r_need) begin
                        n_i     = r_i + AW'(1) - AW'(r_need);
                        n_state = S_EMIT_C;
                    end else begin
                        n_run = run_inc;
                        n_i   = r_i + AW'(1);
                    end
                end else begin
                    n_run = '0;
                    n_i   = r_i + AW'(1);
                end
            end
            S_EMIT_C: begin
                if (can_emit) begin
                    n_used[bidx]       = 1'b1;
                    own_we             = 1'b1;
                    emit_en            = 1'b1;
                    beat.status        = ST_OK;
                    beat.has_block     = 1'b1;
                    beat.block_number  = BNUM_W'(r_i);
                    beat.block_ordinal = ORD_W'(r_n);
                    beat.last          = (n_inc == r_need);
                    n_i = r_i + AW'(1);
                    n_n = n_inc;
                    if (n_inc == r_need) begin
                        n_state = S_RECORD;
                    end
                end
            end
            S_SCAT: begin
                if (r_n == r_need || r_i == lim) begin
                    n_state = S_RECORD;
                end else if (r_used[bidx]) begin
                    n_i = r_i + AW'(1);
                end else if (can_emit) begin
                    n_used[bidx]       = 1'b1;
                    own_we             = 1'b1;
                    emit_en            = 1'b1;
                    beat.status        = ST_OK;
                    beat.has_block     = 1'b1;
                    beat.block_number  = BNUM_W'(r_i);
                    beat.block_ordinal = ORD_W'(r_n);
                    beat.last          = (n_inc == r_need);
                    n_i = r_i + AW'(1);
                    n_n = n_inc;
                end
            end
            S_RECORD: begin
                key_we    = 1'b1;
                cnt_we    = 1'b1;
                ord_we    = 1'b1;
                ord_waddr = r_file_count[SW-1:0];
                n_busy[r_slot] = 1'b1;
                n_file_count   = r_file_count + CW'(1);
                // an empty scattered create still answers with one beat
                n_status = ST_OK;
                n_state  = (r_need == '0) ? S_SINGLE : S_IDLE;
            end
            S_DL_ORD: begin
                ord_raddr = r_fi[SW-1:0];
                if (r_fi == r_file_count) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_SINGLE;
                end else begin
                    n_state = S_DL_SLOT;
                end
            end
            S_DL_SLOT: begin
                n_slot    = ord_q;
                key_raddr = ord_q;
                n_state   = S_DL_KEY;
            end
            S_DL_KEY: begin
                if (key_q == r_key) begin
                    n_i     = '0;
                    n_pv    = 1'b0;
                    n_state = S_DL_FREE;
                end else begin
                    n_fi    = r_fi + CW'(1);
                    n_state = S_DL_ORD;
                end
            end
            S_DL_FREE: begin
                // owner read issued for r_i, its data checked in the next cycle against r_pa
                own_raddr = bidx;
                n_pa      = bidx;
                n_pv      = (r_i != AW'(NUM_BLOCKS));
                if (r_i != AW'(NUM_BLOCKS)) begin
                    n_i = r_i + AW'(1);
                end
                if (r_pv && r_used[r_pa] && own_q == r_slot) begin
                    n_used[r_pa] = 1'b0;
                end
                if (r_i == AW'(NUM_BLOCKS) && !r_pv) begin
                    n_state = S_SH_RD;
                end
            end
            S_SH_RD: begin
                ord_raddr = SW'(r_fi + CW'(1));
                if (r_fi + CW'(1) >= r_file_count) begin
                    n_state = S_DL_END;
                end else begin
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                ord_we    = 1'b1;
                ord_waddr = r_fi[SW-1:0];
                ord_wdata = ord_q;
                n_fi      = r_fi + CW'(1);
                n_state   = S_SH_RD;
            end
            S_DL_END: begin
                n_busy[r_slot] = 1'b0;
                n_file_count   = r_file_count - CW'(1);
                n_status       = ST_OK;
                n_state        = S_SINGLE;
            end
            S_SINGLE: begin
                if (can_emit) begin
                    emit_en     = 1'b1;
                    beat.status = r_status;
                    beat.last   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_busy       <= '0;
            r_file_count <= '0;
            r_bu         <= BU_W'(256);
            r_bpb        <= BPB_W'(512);
            r_out_valid  <= 1'b0;
            r_repacked   <= 1'b0;
            r_pv         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_busy       <= n_busy;
            r_file_count <= n_file_count;
            r_repacked   <= n_repacked;
            r_pv         <= n_pv;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_BLOCKS_IN_USE) begin
                    r_bu <= i_cfg_data[BU_W-1:0];
                end else begin
                    r_bpb <= i_cfg_data;
                end
            end
            if (emit_en) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_free   <= n_free;
        r_fi     <= n_fi;
        r_n      <= n_n;
        r_run    <= n_run;
        r_left   <= n_left;
        r_need   <= n_need;
        r_slot   <= n_slot;
        r_pa     <= n_pa;
        r_status <= n_status;
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_size   <= n_size;
        if (emit_en) begin
            r_out <= beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // slot-busy bits mirror the table
    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_busy) == int'(r_file_count))
        else $error("slot busy bits disagree with file count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_file_count) <= 32'(MAX_FILES))
        else $error("file count above table size");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second command taken while working");

    a_block_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.has_block) |-> o_out_data.status == ST_OK)
        else $error("allocated block reported with error status");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_data))
        else $error("stalled result beat overwritten");

endmodule
